@@ rtl/lphm_pkg.sv @@
// Shared widths, operation codes, result codes and slot status codes of the hash map.
`default_nettype none
package lphm_pkg;

  localparam int FUNC_W = 2;
  localparam int KEY_W  = 64;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;
  localparam int CFG_W  = 7;
  localparam int SLOT_W = 2;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_KEY_BYTES   = 8;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 7'd64;

  localparam logic [FUNC_W-1:0] FN_GET    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_PUT    = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] RS_OK     = 2'd0;
  localparam logic [STAT_W-1:0] RS_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] RS_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] RS_DUP    = 2'd3;

  localparam logic [SLOT_W-1:0] SL_EMPTY = 2'd0;
  localparam logic [SLOT_W-1:0] SL_LIVE  = 2'd1;
  localparam logic [SLOT_W-1:0] SL_TOMB  = 2'd2;

endpackage
`default_nettype wire

@@ rtl/lphm_intf.sv @@
// Channel interfaces of the hash map: request items, result items and the size register write.
`default_nettype none
interface lphm_in_if;
  logic                              valid;
  logic                              ready;
  logic [lphm_pkg::FUNC_W-1:0]       func;
  logic [lphm_pkg::KEY_W-1:0]        key;
  logic signed [lphm_pkg::VAL_W-1:0] value;
  modport source (output valid, func, key, value, input ready);
  modport sink (input valid, func, key, value, output ready);
endinterface

interface lphm_out_if;
  logic                              valid;
  logic                              ready;
  logic [lphm_pkg::STAT_W-1:0]       status;
  logic signed [lphm_pkg::VAL_W-1:0] value_out;
  logic [lphm_pkg::CNT_W-1:0]        entry_count_out;
  logic                              is_empty;
  modport source (output valid, status, value_out, entry_count_out, is_empty, input ready);
  modport sink (input valid, status, value_out, entry_count_out, is_empty, output ready);
endinterface

interface lphm_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lphm_pkg::CFG_W-1:0] table_size;
  modport source (output valid, table_size, input ready);
  modport sink (input valid, table_size, output ready);
endinterface
`default_nettype wire

@@ rtl/lphm_mod.sv @@
// Iterative remainder unit that reduces a key byte modulo the table size, one bit per cycle.
`default_nettype none
module lphm_mod #(
  parameter int NW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [7:0]    dividend,
  input  wire logic [NW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      rem
);

  logic          run_r;
  logic          done_r;
  logic [2:0]    step_r;
  logic [7:0]    dvd_r;
  logic [NW-1:0] dvs_r;
  logic [NW-1:0] rem_r;
  logic [NW:0]   trial;
  logic [NW-1:0] rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[7]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = NW'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd7) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[6:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

@@ rtl/linear_probe_hash_map_top.sv @@
// Top level of the linear probing hash map with tombstones, holding the slot memory and sequencer.
//
// Requests arrive on in_ch (func, key, value) and each one yields exactly one result item
// on out_ch (status, value_out, entry_count_out, is_empty). Items are handled one at a time.
// An accepted item first passes through a bit-serial remainder unit that finds the home
// slot; a put that would bring the entry count above half the table size then skips the
// probe. Otherwise the item probes the slot memory slot by slot, each probe a read state
// and a check state that may also write back, and the output register is loaded last.
// The result waits in the output register until out_ch.ready is high; a new request is
// accepted meanwhile, and its own result is held back until the register is free.
// cfg_ch writes the table size at any time and is always ready; it should only be written
// while no item is in flight. After reset the block clears the status of every slot, one
// slot per cycle, so in_ch.ready stays low until the last slot is cleared. The live
// entry count resets to zero and the table size to 64.
`default_nettype none
module linear_probe_hash_map_top #(
  parameter int TABLE_DEPTH = lphm_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BYTES   = lphm_pkg::DEF_KEY_BYTES
) (
  input wire logic  clk,
  input wire logic  rst_n,
  lphm_in_if.sink   in_ch,
  lphm_out_if.source out_ch,
  lphm_cfg_if.sink  cfg_ch
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW    = (IDX_W + 1 > lphm_pkg::CFG_W) ? IDX_W + 1 : lphm_pkg::CFG_W;
  localparam int LW    = ((NW > 8) ? NW : 8) + 1;
  localparam int KW    = 8 * KEY_BYTES;
  localparam int VW    = lphm_pkg::VAL_W;
  localparam int SW    = lphm_pkg::SLOT_W;
  localparam int MW    = SW + KW + VW;
  localparam int CW    = lphm_pkg::CNT_W;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_READ  = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_t;

  state_t                      state_r;
  logic [IDX_W-1:0]            clr_addr_r;
  logic [lphm_pkg::CFG_W-1:0]  table_size_r;
  logic [NW-1:0]               n_eff;
  logic [NW-1:0]               n_r;
  logic [lphm_pkg::FUNC_W-1:0] func_r;
  logic [KW-1:0]               key_r;
  logic [VW-1:0]               val_r;
  logic [IDX_W-1:0]            pos_r;
  logic [IDX_W-1:0]            pos_next;
  logic [NW-1:0]               probes_r;
  logic                        free_vld_r;
  logic [IDX_W-1:0]            free_pos_r;
  logic [lphm_pkg::STAT_W-1:0] status_r;
  logic [VW-1:0]               vout_r;
  logic [CW-1:0]               count_r;
  logic                        out_valid_r;
  logic [lphm_pkg::STAT_W-1:0] out_status_r;
  logic [VW-1:0]               out_value_r;
  logic [CW-1:0]               out_count_r;
  logic                        out_empty_r;

  logic [MW-1:0]               slot_mem [TABLE_DEPTH];
  logic [MW-1:0]               rd_q_r;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_addr;
  logic [MW-1:0]               mem_wdata;

  logic [SW-1:0]               rd_st;
  logic [KW-1:0]               rd_key;
  logic [VW-1:0]               rd_val;
  logic                        rd_live;
  logic                        rd_hit;
  logic                        last_probe;
  logic                        stop;
  logic                        have_free;
  logic [IDX_W-1:0]            free_addr;
  logic                        overload;
  logic                        accept;
  logic                        mod_done;
  logic [NW-1:0]               mod_rem;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    if (table_size_r == '0) begin
      n_eff = NW'(1);
    end else if (NW'(table_size_r) > NW'(TABLE_DEPTH)) begin
      n_eff = NW'(TABLE_DEPTH);
    end else begin
      n_eff = NW'(table_size_r);
    end
  end

  lphm_mod #(
    .NW (NW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (in_ch.key[7:0]),
    .divisor  (n_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign rd_st   = rd_q_r[MW-1 -: SW];
  assign rd_key  = rd_q_r[KW+VW-1:VW];
  assign rd_val  = rd_q_r[VW-1:0];
  assign rd_live = (rd_st == lphm_pkg::SL_LIVE);
  assign rd_hit  = rd_live && (rd_key == key_r);

  assign last_probe = ((probes_r + NW'(1)) == n_r);
  assign stop       = (rd_st == lphm_pkg::SL_EMPTY) || last_probe;
  assign pos_next   = ((NW'(pos_r) + NW'(1)) == n_r) ? '0 : pos_r + IDX_W'(1);
  assign have_free  = free_vld_r || !rd_live;
  assign free_addr  = free_vld_r ? free_pos_r : pos_r;
  assign overload   = ((LW'(count_r) + LW'(1)) << 1) > LW'(n_r);

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = pos_r;
    mem_wdata = {lphm_pkg::SL_LIVE, key_r, val_r};
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr_r;
        mem_wdata = {lphm_pkg::SL_EMPTY, {(KW + VW){1'b0}}};
      end
      S_CHECK: begin
        if (rd_hit && func_r == lphm_pkg::FN_REMOVE) begin
          mem_we    = 1'b1;
          mem_wdata = {lphm_pkg::SL_TOMB, rd_key, rd_val};
        end else if (!rd_hit && stop && func_r == lphm_pkg::FN_PUT && have_free) begin
          mem_we   = 1'b1;
          mem_addr = free_addr;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_addr] <= mem_wdata;
    end
    rd_q_r <= slot_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= lphm_pkg::TABLE_SIZE_RST;
    end else if (cfg_ch.valid) begin
      table_size_r <= cfg_ch.table_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + IDX_W'(1);
          if (clr_addr_r == IDX_W'(TABLE_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            if (func_r == lphm_pkg::FN_GET || func_r == lphm_pkg::FN_REMOVE ||
                (func_r == lphm_pkg::FN_PUT && !overload)) begin
              state_r <= S_READ;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_READ: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (rd_hit || stop) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_READ;
          end
          if (rd_hit && func_r == lphm_pkg::FN_REMOVE && count_r != '0) begin
            count_r <= count_r - CW'(1);
          end else if (!rd_hit && stop && func_r == lphm_pkg::FN_PUT && have_free) begin
            count_r <= count_r + CW'(1);
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_ch.func;
      key_r  <= in_ch.key[KW-1:0];
      val_r  <= in_ch.value;
      n_r    <= n_eff;
    end
    case (state_r)
      S_MOD: begin
        pos_r      <= mod_rem[IDX_W-1:0];
        probes_r   <= '0;
        free_vld_r <= 1'b0;
        vout_r     <= '0;
        status_r   <= (func_r == lphm_pkg::FN_PUT) ? lphm_pkg::RS_FULL : lphm_pkg::RS_OK;
      end
      S_CHECK: begin
        if (rd_hit) begin
          if (func_r == lphm_pkg::FN_PUT) begin
            status_r <= lphm_pkg::RS_DUP;
          end else begin
            status_r <= lphm_pkg::RS_OK;
            vout_r   <= rd_val;
          end
        end else if (stop) begin
          if (func_r == lphm_pkg::FN_PUT) begin
            status_r <= have_free ? lphm_pkg::RS_OK : lphm_pkg::RS_FULL;
          end else begin
            status_r <= lphm_pkg::RS_ABSENT;
          end
        end else begin
          pos_r    <= pos_next;
          probes_r <= probes_r + NW'(1);
          if (!rd_live && !free_vld_r) begin
            free_vld_r <= 1'b1;
            free_pos_r <= pos_r;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_status_r <= status_r;
          out_value_r  <= vout_r;
          out_count_r  <= count_r;
          out_empty_r  <= (count_r == '0);
        end
      end
      default: begin
        free_vld_r <= free_vld_r;
      end
    endcase
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.value_out       = $signed(out_value_r);
  assign out_ch.entry_count_out = out_count_r;
  assign out_ch.is_empty        = out_empty_r;

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CW'(1) || count_r == $past(count_r) - CW'(1)))
    else $error("Live entry count moved by more than one.");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_CHECK))
    else $error("Slot memory written outside clearing or checking.");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("Result item raised without a finished request.");

endmodule
`default_nettype wire
